/* design/scs_pkg.sv */
// ----------------------------------------------------------------------------
// Spring chain surface step: shared package
// Field widths, register indexes, operation codes, reset values and the
// control word passed from the sequencer to the arithmetic unit.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int DEF_MAX_PARTICLES = 256;
	localparam int DEF_STATE_BITS    = 24;

	localparam int FUNC_BITS     = 2;
	localparam int INDEX_BITS    = 8;
	localparam int VALUE_BITS    = 24;
	localparam int AMP_BITS      = 17;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int COEF_BITS     = 16;
	localparam int DAMP_BITS     = 13;
	localparam int SUB_BITS      = 4;
	localparam int CNT_BITS      = 9;
	localparam int BASE_BITS     = 16;

	localparam int MIN_PARTICLES = 3;
	localparam int FRAC_Q16      = 16;
	localparam int FRAC_Q12      = 12;
	localparam int HALF_Q12      = 2048;
	localparam int AMP_MAX       = 65535;
	localparam int AMP_MIN       = -65536;

	localparam logic [COEF_BITS-1:0] RST_COUPLING  = 16'd4096;
	localparam logic [COEF_BITS-1:0] RST_RESTORE   = 16'd512;
	localparam logic [DAMP_BITS-1:0] RST_DAMPING   = 13'd4000;
	localparam logic [SUB_BITS-1:0]  RST_SUBSTEPS  = 4'd1;
	localparam logic [CNT_BITS-1:0]  RST_COUNT     = 9'd256;
	localparam logic [BASE_BITS-1:0] RST_BASE      = 16'd0;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_STEP = 2'd0,
		FN_SET  = 2'd1,
		FN_ADD  = 2'd2,
		FN_READ = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COUPLING = 3'd0,
		REG_RESTORE  = 3'd1,
		REG_DAMPING  = 3'd2,
		REG_SUBSTEPS = 3'd3,
		REG_COUNT    = 3'd4,
		REG_BASE     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} scs_ctrl_t;

endpackage

/* design/scs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/scs_alu.sv */
// ----------------------------------------------------------------------------
// Spring chain surface step: arithmetic unit
// Spring force products, velocity and height update with saturation,
// damping product, and the single-particle set, add and read arithmetic.
// ----------------------------------------------------------------------------
module scs_alu #(
	parameter int W = scs_pkg::DEF_STATE_BITS
) (
	input  logic                                  clk,
	input  scs_pkg::scs_ctrl_t                    ctrl,
	input  logic        [scs_pkg::COEF_BITS-1:0]  coupling,
	input  logic        [scs_pkg::COEF_BITS-1:0]  restore,
	input  logic        [scs_pkg::DAMP_BITS-1:0]  damping,
	input  logic signed [scs_pkg::BASE_BITS-1:0]  base,
	input  logic signed [W-1:0]                   h_left,
	input  logic signed [W-1:0]                   h_mid,
	input  logic signed [W-1:0]                   h_right,
	input  logic signed [W-1:0]                   h_rd,
	input  logic signed [W-1:0]                   v_rd,
	input  logic signed [scs_pkg::VALUE_BITS-1:0] hv,
	input  logic signed [scs_pkg::VALUE_BITS-1:0] vv,
	output logic signed [W-1:0]                   h_new,
	output logic signed [W-1:0]                   v_new,
	output logic signed [W-1:0]                   v_damp,
	output logic signed [W-1:0]                   h_set,
	output logic signed [W-1:0]                   v_set,
	output logic signed [W-1:0]                   v_add,
	output logic signed [scs_pkg::AMP_BITS-1:0]   amp
);

	import scs_pkg::*;

	localparam int FW  = W + 2;
	localparam int PNW = FW + COEF_BITS + 1;
	localparam int PZW = W + COEF_BITS + 1;
	localparam int PDW = W + DAMP_BITS + 1;
	localparam int XW  = PNW + 1;

	localparam logic signed [XW-1:0] S_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] S_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [XW-1:0] A_HI = XW'(AMP_MAX);
	localparam logic signed [XW-1:0] A_LO = XW'(AMP_MIN);
	localparam logic signed [XW-1:0] RND  = XW'(HALF_Q12);

	function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] x);
		logic signed [W-1:0] r;
		if (x > S_HI) begin
			r = S_HI[W-1:0];
		end else if (x < S_LO) begin
			r = S_LO[W-1:0];
		end else begin
			r = x[W-1:0];
		end
		return r;
	endfunction

	logic signed [FW-1:0]  f;
	logic signed [PNW-1:0] prod_n_s1;
	logic signed [PZW-1:0] prod_z_s1;
	logic signed [PDW-1:0] prod_d_s1;
	logic signed [W-1:0]   vold_s1;
	logic signed [W-1:0]   v_new_s2;
	logic signed [XW-1:0]  acc;
	logic signed [XW-1:0]  vsum;
	logic signed [XW-1:0]  a_wide;

	assign f = FW'(h_left) + FW'(h_right) - (FW'(h_mid) <<< 1);

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			prod_n_s1 <= f * $signed({1'b0, coupling});
			prod_z_s1 <= h_mid * $signed({1'b0, restore});
			prod_d_s1 <= v_rd * $signed({1'b0, damping});
			vold_s1   <= v_rd;
		end
		if (ctrl.ld_s2) begin
			v_new_s2 <= sat(vsum);
		end
	end

	assign acc    = XW'(prod_n_s1) - XW'(prod_z_s1);
	assign vsum   = XW'(vold_s1) + (acc >>> FRAC_Q16);
	assign v_new  = v_new_s2;
	assign h_new  = sat(XW'(h_mid) + XW'(v_new_s2));
	assign v_damp = sat((XW'(prod_d_s1) + RND) >>> FRAC_Q12);
	assign h_set  = sat(XW'(hv));
	assign v_set  = sat(XW'(vv));
	assign v_add  = sat(XW'(v_rd) + XW'(vv));
	assign a_wide = ((XW'(h_rd) + RND) >>> FRAC_Q12) + XW'(base);

	always_comb begin
		if (a_wide > A_HI) begin
			amp = A_HI[AMP_BITS-1:0];
		end else if (a_wide < A_LO) begin
			amp = A_LO[AMP_BITS-1:0];
		end else begin
			amp = a_wide[AMP_BITS-1:0];
		end
	end

endmodule

/* design/spring_chain_surface_step_unit.sv */
// ----------------------------------------------------------------------------
// Spring chain surface step unit
// A chain of particles with Q12 height and velocity, held in two RAMs.
// Input words carry func, index, height_value and velocity_value; each one
// yields exactly one output word (amplitude, bad_index). Both channels use
// valid/stall. Configuration is written through wr_en/wr_index/wr_data;
// the user must write it only while the unit is idle, and the block itself
// does not enforce this. After reset a clearing pass zeroes every address
// of both RAMs, with in_stall high. Then one word is worked at a time. A
// step walks the chain once per substep (read, multiply, velocity, write
// back for each particle) and once more to damp (read, multiply, write
// back for each particle), bound by the single read port of each RAM. A
// neighbour window in registers keeps old heights.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver stalls, a finished word holds until that register
// empties.
// ----------------------------------------------------------------------------
module spring_chain_surface_step_unit #(
	parameter int MAX_PARTICLES = scs_pkg::DEF_MAX_PARTICLES,
	parameter int STATE_BITS    = scs_pkg::DEF_STATE_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic        [scs_pkg::FUNC_BITS-1:0]     func,
	input  logic        [scs_pkg::INDEX_BITS-1:0]    index,
	input  logic signed [scs_pkg::VALUE_BITS-1:0]    height_value,
	input  logic signed [scs_pkg::VALUE_BITS-1:0]    velocity_value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [scs_pkg::AMP_BITS-1:0]      amplitude,
	output logic                                     bad_index,
	input  logic                                     wr_en,
	input  logic        [scs_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic        [scs_pkg::CFG_DATA_BITS-1:0] wr_data
);

	import scs_pkg::*;

	localparam int W  = STATE_BITS;
	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int EW = (CW > CNT_BITS) ? CW : CNT_BITS;

	localparam logic [EW-1:0] MAX_W    = EW'(MAX_PARTICLES);
	localparam logic [EW-1:0] MIN_W    = EW'(MIN_PARTICLES);
	localparam logic [CW-1:0] CLR_LAST = CW'(MAX_PARTICLES - 1);

	typedef enum logic [14:0] {
		S_CLEAR = 15'h0001,
		S_IDLE  = 15'h0002,
		S_SET   = 15'h0004,
		S_OPRD  = 15'h0008,
		S_OPX   = 15'h0010,
		S_PRE   = 15'h0020,
		S_LOAD  = 15'h0040,
		S_RD    = 15'h0080,
		S_MUL   = 15'h0100,
		S_ACC   = 15'h0200,
		S_WR    = 15'h0400,
		S_DRD   = 15'h0800,
		S_DMUL  = 15'h1000,
		S_DWR   = 15'h2000,
		S_DONE  = 15'h4000
	} state_t;

	state_t state_q, state_d;

	logic        [COEF_BITS-1:0] reg_nc_q;
	logic        [COEF_BITS-1:0] reg_rf_q;
	logic        [DAMP_BITS-1:0] reg_df_q;
	logic        [SUB_BITS-1:0]  reg_sub_q;
	logic        [CNT_BITS-1:0]  reg_cnt_q;
	logic signed [BASE_BITS-1:0] reg_base_q;

	logic        [CW-1:0]         i_q;
	logic        [SUB_BITS-1:0]   sub_q;
	func_t                        func_q;
	logic        [INDEX_BITS-1:0] idx_q;
	logic signed [VALUE_BITS-1:0] hv_q;
	logic signed [VALUE_BITS-1:0] vv_q;
	logic signed [W-1:0]          hl_q;
	logic signed [W-1:0]          hc_q;
	logic signed [W-1:0]          hr_q;
	logic signed [AMP_BITS-1:0]   res_amp_q;
	logic                         res_bad_q;
	logic                         out_valid_q;
	logic signed [AMP_BITS-1:0]   amplitude_q;
	logic                         bad_index_q;

	logic [EW-1:0]   cnt_w;
	logic [EW-1:0]   eff_w;
	logic [CW-1:0]   i_nxt;
	logic            i_last;
	logic            clr_end;
	logic [AW-1:0]   i_addr;
	logic [EW-1:0]   idx_w;
	logic [AW-1:0]   idx_addr;
	logic            bad_in;
	logic            acc_in;
	logic            slot_free;
	func_t           fn_in;

	logic            h_we, v_we;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   h_raddr, v_raddr;
	logic signed [W-1:0] h_wdata, v_wdata;
	logic signed [W-1:0] h_rd, v_rd;
	logic signed [W-1:0] h_right;

	scs_ctrl_t           ctrl;
	logic signed [W-1:0] h_new, v_new, v_damp, h_set, v_set, v_add;
	logic signed [AMP_BITS-1:0] amp;

	assign cnt_w    = EW'(reg_cnt_q);
	assign eff_w    = (cnt_w < MIN_W) ? MIN_W : ((cnt_w > MAX_W) ? MAX_W : cnt_w);
	assign i_nxt    = i_q + CW'(1);
	assign i_last   = (EW'(i_q) == (eff_w - EW'(1)));
	assign clr_end  = (i_q == CLR_LAST);
	assign i_addr   = i_q[AW-1:0];
	assign idx_w    = EW'(idx_q);
	assign idx_addr = idx_w[AW-1:0];
	assign fn_in    = func_t'(func);
	assign bad_in   = (fn_in != FN_STEP) && (EW'(index) >= eff_w);
	assign in_stall = (state_q != S_IDLE);
	assign acc_in   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign h_right  = i_last ? '0 : h_rd;

	assign out_valid = out_valid_q;
	assign amplitude = amplitude_q;
	assign bad_index = bad_index_q;

	always_comb begin
		state_d = state_q;
		h_we    = 1'b0;
		v_we    = 1'b0;
		waddr   = i_addr;
		h_wdata = '0;
		v_wdata = '0;
		h_raddr = idx_addr;
		v_raddr = idx_addr;
		ctrl    = '0;
		unique case (state_q)
			S_CLEAR: begin
				h_we = 1'b1;
				v_we = 1'b1;
				if (clr_end) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (acc_in) begin
					if (bad_in) begin
						state_d = S_DONE;
					end else begin
						unique case (fn_in) inside
							FN_STEP: state_d = (reg_sub_q == '0) ? S_DRD : S_PRE;
							FN_SET: state_d = S_SET;
							FN_ADD, FN_READ: state_d = S_OPRD;
							default: state_d = S_DONE;
						endcase
					end
				end
			end
			S_SET: begin
				h_we    = 1'b1;
				v_we    = 1'b1;
				waddr   = idx_addr;
				h_wdata = h_set;
				v_wdata = v_set;
				state_d = S_DONE;
			end
			S_OPRD: begin
				state_d = S_OPX;
			end
			S_OPX: begin
				if (func_q == FN_ADD) begin
					v_we    = 1'b1;
					waddr   = idx_addr;
					v_wdata = v_add;
				end
				state_d = S_DONE;
			end
			S_PRE: begin
				h_raddr = '0;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = S_RD;
			end
			S_RD: begin
				h_raddr = i_nxt[AW-1:0];
				v_raddr = i_addr;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctrl.ld_s1 = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				ctrl.ld_s2 = 1'b1;
				state_d    = S_WR;
			end
			S_WR: begin
				h_we    = 1'b1;
				v_we    = 1'b1;
				h_wdata = h_new;
				v_wdata = v_new;
				if (i_last) begin
					state_d = (sub_q == SUB_BITS'(1)) ? S_DRD : S_PRE;
				end else begin
					state_d = S_RD;
				end
			end
			S_DRD: begin
				v_raddr = i_addr;
				state_d = S_DMUL;
			end
			S_DMUL: begin
				ctrl.ld_s1 = 1'b1;
				state_d    = S_DWR;
			end
			S_DWR: begin
				v_we    = 1'b1;
				v_wdata = v_damp;
				state_d = i_last ? S_DONE : S_DRD;
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			i_q         <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
			reg_nc_q    <= RST_COUPLING;
			reg_rf_q    <= RST_RESTORE;
			reg_df_q    <= RST_DAMPING;
			reg_sub_q   <= RST_SUBSTEPS;
			reg_cnt_q   <= RST_COUNT;
			reg_base_q  <= RST_BASE;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (cfg_reg_t'(wr_index))
					REG_COUPLING: reg_nc_q   <= wr_data[COEF_BITS-1:0];
					REG_RESTORE:  reg_rf_q   <= wr_data[COEF_BITS-1:0];
					REG_DAMPING:  reg_df_q   <= wr_data[DAMP_BITS-1:0];
					REG_SUBSTEPS: reg_sub_q  <= wr_data[SUB_BITS-1:0];
					REG_COUNT:    reg_cnt_q  <= wr_data[CNT_BITS-1:0];
					REG_BASE:     reg_base_q <= wr_data[BASE_BITS-1:0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) begin
				i_q <= clr_end ? '0 : i_nxt;
			end else if (acc_in) begin
				i_q   <= '0;
				sub_q <= reg_sub_q;
			end else if (state_q == S_WR || state_q == S_DWR) begin
				i_q <= i_last ? '0 : i_nxt;
				if (state_q == S_WR && i_last) begin
					sub_q <= sub_q - SUB_BITS'(1);
				end
			end
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			func_q    <= fn_in;
			idx_q     <= index;
			hv_q      <= height_value;
			vv_q      <= velocity_value;
			res_bad_q <= bad_in;
			res_amp_q <= '0;
		end
		if (state_q == S_OPX && func_q == FN_READ) begin
			res_amp_q <= amp;
		end
		if (state_q == S_LOAD) begin
			hc_q <= h_rd;
			hl_q <= '0;
		end
		if (state_q == S_MUL) begin
			hr_q <= h_right;
		end
		if (state_q == S_WR) begin
			hl_q <= hc_q;
			hc_q <= hr_q;
		end
		if (state_q == S_DONE && slot_free) begin
			amplitude_q <= res_amp_q;
			bad_index_q <= res_bad_q;
		end
	end

	scs_ram #(
		.WIDTH (W),
		.DEPTH (MAX_PARTICLES)
	) u_h_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rd)
	);

	scs_ram #(
		.WIDTH (W),
		.DEPTH (MAX_PARTICLES)
	) u_v_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rd)
	);

	scs_alu #(
		.W (W)
	) u_alu (
		.clk      (clk),
		.ctrl     (ctrl),
		.coupling (reg_nc_q),
		.restore  (reg_rf_q),
		.damping  (reg_df_q),
		.base     (reg_base_q),
		.h_left   (hl_q),
		.h_mid    (hc_q),
		.h_right  (h_right),
		.h_rd     (h_rd),
		.v_rd     (v_rd),
		.hv       (hv_q),
		.vv       (vv_q),
		.h_new    (h_new),
		.v_new    (v_new),
		.v_damp   (v_damp),
		.h_set    (h_set),
		.v_set    (v_set),
		.v_add    (v_add),
		.amp      (amp)
	);

endmodule

/* design/scs_chk.sv */
// ----------------------------------------------------------------------------
// Spring chain surface step: port checker
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module scs_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [scs_pkg::AMP_BITS-1:0] amplitude,
	input logic                                bad_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(amplitude) && $stable(bad_index))
		else $error("stalled output word changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> amplitude == '0)
		else $error("rejected word carries a nonzero amplitude");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken before the first finished");

	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result shown while still busy");

endmodule

bind spring_chain_surface_step_unit scs_chk u_scs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.amplitude (amplitude),
	.bad_index (bad_index)
);
